// ----- rtl/cpdq_pkg.sv -----
// shared types, codes and defaults for the checksummed packet deframer queue
// no dependencies

package cpdq_pkg;

   // default sizes
   localparam int QUEUE_SLOTS_DEF      = 8;
   localparam int MAX_PACKET_BYTES_DEF = 32;

   // depth of the command queue between front and back
   localparam int CMD_FIFO_DEPTH = 4;

   // register file
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_FIRST  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_SECOND = 1'b1;
   localparam logic [7:0] HEADER_FIRST_RST  = 8'h01;
   localparam logic [7:0] HEADER_SECOND_RST = 8'h02;

   // request opcodes
   localparam logic [1:0] OP_RX      = 2'd0;
   localparam logic [1:0] OP_TIMEOUT = 2'd1;
   localparam logic [1:0] OP_POP     = 2'd2;

   // classified commands
   localparam logic [1:0] CMD_NOP  = 2'd0;
   localparam logic [1:0] CMD_RX   = 2'd1;
   localparam logic [1:0] CMD_TMO  = 2'd2;
   localparam logic [1:0] CMD_POP  = 2'd3;

   // result events
   localparam logic [2:0] EV_NONE   = 3'd0;
   localparam logic [2:0] EV_ACCEPT = 3'd1;
   localparam logic [2:0] EV_BADSUM = 3'd2;
   localparam logic [2:0] EV_TRUNC  = 3'd3;
   localparam logic [2:0] EV_LONG   = 3'd4;
   localparam logic [2:0] EV_FULL   = 3'd5;
   localparam logic [2:0] EV_BYTE   = 3'd6;
   localparam logic [2:0] EV_EMPTY  = 3'd7;

   // framer phases
   localparam logic [1:0] PH_HUNT    = 2'd0;
   localparam logic [1:0] PH_LEN     = 2'd1;
   localparam logic [1:0] PH_STORE   = 2'd2;
   localparam logic [1:0] PH_DISCARD = 2'd3;

   localparam int QUEUED_W = 4;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]          event_res;
      logic [7:0]          pkt_length;
      logic [7:0]          data_byte;
      logic                last;
      logic                ready_res;
      logic [QUEUED_W-1:0] queued;
   } rsp_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
   } cmd_type;

endpackage

// ----- rtl/cpdq_front.sv -----
// front end: takes requests, classifies them and queues the commands
// depends on cpdq_pkg

module cpdq_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cpdq_pkg::req_type req_payload,
   output logic              cmd_valid,
   input  logic              cmd_take,
   output cpdq_pkg::cmd_type cmd
);
   import cpdq_pkg::*;

   localparam int PTR_W = $clog2(CMD_FIFO_DEPTH);
   localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

   cmd_type           fifo_ff [CMD_FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   cmd_type           cls;
   logic              push, pop;

   // classify the request
   always_comb begin
      cls.data = req_payload.rx_byte;
      case (req_payload.opcode)
         OP_RX:      cls.kind = CMD_RX;
         OP_TIMEOUT: cls.kind = CMD_TMO;
         OP_POP:     cls.kind = CMD_POP;
         default:    cls.kind = CMD_NOP;
      endcase
   end

   assign req_stall = (count_ff == CNT_W'(CMD_FIFO_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_take && cmd_valid;
   assign cmd       = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ----- rtl/cpdq_back.sv -----
// back end: framer, packet ring, pop streaming and result registers
// depends on cpdq_pkg

module cpdq_back #(
   parameter int QUEUE_SLOTS      = cpdq_pkg::QUEUE_SLOTS_DEF,
   parameter int MAX_PACKET_BYTES = cpdq_pkg::MAX_PACKET_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        header_first,
   input  logic [7:0]        header_second,
   input  logic              cmd_valid,
   output logic              cmd_take,
   input  cpdq_pkg::cmd_type cmd,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cpdq_pkg::rsp_type rsp_payload
);
   import cpdq_pkg::*;

   localparam int IDX_W   = $clog2(QUEUE_SLOTS);
   localparam int FILL_W  = $clog2(QUEUE_SLOTS + 1);
   localparam int LEN_W   = $clog2(MAX_PACKET_BYTES + 1);
   localparam int DEPTH   = QUEUE_SLOTS * MAX_PACKET_BYTES;
   localparam int ADDR_W  = $clog2(DEPTH);

   // packet memory and slot lengths
   logic [7:0]        pkt_mem_ff [DEPTH];
   logic [7:0]        rd_data_ff;
   logic [LEN_W-1:0]  slot_len_ff [QUEUE_SLOTS];

   // framer state
   logic [1:0]        phase_ff, phase_in;
   logic [7:0]        prev_ff, prev_in;
   logic [7:0]        last_ff, last_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic [LEN_W-1:0]  exp_len_ff, exp_len_in;
   logic [7:0]        sum_ff, sum_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   // pop streaming
   logic              pop_busy_ff, pop_busy_in;
   logic [LEN_W-1:0]  pop_len_ff, pop_len_in;
   logic [LEN_W-1:0]  pop_cnt_ff, pop_cnt_in;
   logic [ADDR_W-1:0] pop_addr_ff, pop_addr_in;

   // result pipeline: s1 waits for memory data, then the output register
   logic              s1_valid_ff, s1_valid_in;
   rsp_type           s1_ff, s1_in;
   logic              s1_byte_ff, s1_byte_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;

   logic              adv;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa;
   logic [ADDR_W-1:0] rd_addr;
   logic              slot_we;
   logic [LEN_W-1:0]  start_len;
   logic [ADDR_W-1:0] tail_base;
   logic [ADDR_W-1:0] head_base;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign start_len = slot_len_ff[tail_ff];
   assign tail_base = ADDR_W'(tail_ff) * ADDR_W'(MAX_PACKET_BYTES);
   assign head_base = ADDR_W'(head_ff) * ADDR_W'(MAX_PACKET_BYTES);
   assign mem_wa    = head_base + ADDR_W'(cnt_ff);

   always_comb begin
      phase_in    = phase_ff;
      prev_in     = prev_ff;
      last_in     = last_ff;
      cnt_in      = cnt_ff;
      exp_len_in  = exp_len_ff;
      sum_in      = sum_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      fill_in     = fill_ff;
      pop_busy_in = pop_busy_ff;
      pop_len_in  = pop_len_ff;
      pop_cnt_in  = pop_cnt_ff;
      pop_addr_in = pop_addr_ff;
      s1_valid_in = 1'b0;
      s1_byte_in  = 1'b0;
      s1_in       = '0;
      s1_in.event_res = EV_NONE;
      s1_in.last  = 1'b1;
      rd_addr     = pop_addr_ff;
      mem_we      = 1'b0;
      slot_we     = 1'b0;
      cmd_take    = 1'b0;

      if (adv) begin
         if (pop_busy_ff) begin
            // stream the rest of the popped packet
            s1_valid_in       = 1'b1;
            s1_byte_in        = 1'b1;
            s1_in.event_res   = EV_BYTE;
            s1_in.pkt_length  = 8'(pop_len_ff);
            s1_in.last        = (({1'b0, pop_cnt_ff} + 1'b1) == {1'b0, pop_len_ff});
            rd_addr           = pop_addr_ff;
            pop_addr_in       = pop_addr_ff + 1'b1;
            pop_cnt_in        = pop_cnt_ff + 1'b1;
            if (s1_in.last) begin
               pop_busy_in = 1'b0;
            end
         end else if (cmd_valid) begin
            cmd_take    = 1'b1;
            s1_valid_in = 1'b1;
            case (cmd.kind)
               CMD_RX: begin
                  if (phase_ff == PH_HUNT) begin
                     prev_in = last_ff;
                     last_in = cmd.data;
                     if (cnt_ff < LEN_W'(2)) begin
                        cnt_in = cnt_ff + 1'b1;
                     end
                     if (cnt_ff >= LEN_W'(1) && last_ff == header_first &&
                         cmd.data == header_second) begin
                        phase_in = PH_LEN;
                        cnt_in   = '0;
                     end
                  end else if (phase_ff == PH_LEN) begin
                     if (cmd.data == 8'd0) begin
                        s1_in.event_res = EV_BADSUM;
                        phase_in = PH_HUNT;
                        cnt_in   = '0;
                        sum_in   = '0;
                        prev_in  = '0;
                        last_in  = '0;
                     end else if (cmd.data > 8'(MAX_PACKET_BYTES)) begin
                        s1_in.event_res  = EV_LONG;
                        s1_in.pkt_length = cmd.data;
                        phase_in = PH_HUNT;
                        cnt_in   = '0;
                        sum_in   = '0;
                        prev_in  = '0;
                        last_in  = '0;
                     end else begin
                        exp_len_in = LEN_W'(cmd.data);
                        cnt_in     = '0;
                        sum_in     = '0;
                        phase_in   = (fill_ff < FILL_W'(QUEUE_SLOTS)) ? PH_STORE : PH_DISCARD;
                     end
                  end else begin
                     // collecting; in the store phase the bytes land in the head slot
                     mem_we = (phase_ff == PH_STORE);
                     if (({1'b0, cnt_ff} + 1'b1) < {1'b0, exp_len_ff}) begin
                        sum_in = sum_ff + cmd.data;
                        cnt_in = cnt_ff + 1'b1;
                     end else begin
                        s1_in.pkt_length = 8'(exp_len_ff);
                        if (sum_ff != cmd.data) begin
                           s1_in.event_res = EV_BADSUM;
                        end else if (phase_ff == PH_DISCARD ||
                                     fill_ff >= FILL_W'(QUEUE_SLOTS)) begin
                           s1_in.event_res = EV_FULL;
                        end else begin
                           s1_in.event_res = EV_ACCEPT;
                           slot_we = 1'b1;
                           head_in = (head_ff == IDX_W'(QUEUE_SLOTS - 1)) ? '0 :
                                     head_ff + 1'b1;
                           fill_in = fill_ff + 1'b1;
                        end
                        phase_in = PH_HUNT;
                        cnt_in   = '0;
                        sum_in   = '0;
                        prev_in  = '0;
                        last_in  = '0;
                     end
                  end
               end
               CMD_TMO: begin
                  if (phase_ff != PH_HUNT) begin
                     s1_in.event_res = EV_TRUNC;
                     if (phase_ff != PH_LEN) begin
                        s1_in.pkt_length = 8'(exp_len_ff);
                     end
                  end
                  phase_in = PH_HUNT;
                  cnt_in   = '0;
                  sum_in   = '0;
                  prev_in  = '0;
                  last_in  = '0;
               end
               CMD_POP: begin
                  if (fill_ff == '0) begin
                     s1_in.event_res = EV_EMPTY;
                  end else begin
                     s1_byte_in       = 1'b1;
                     s1_in.event_res  = EV_BYTE;
                     s1_in.pkt_length = 8'(start_len);
                     s1_in.last       = (start_len == LEN_W'(1));
                     rd_addr          = tail_base;
                     tail_in = (tail_ff == IDX_W'(QUEUE_SLOTS - 1)) ? '0 : tail_ff + 1'b1;
                     fill_in = fill_ff - 1'b1;
                     if (start_len != LEN_W'(1)) begin
                        pop_busy_in = 1'b1;
                        pop_len_in  = start_len;
                        pop_cnt_in  = LEN_W'(1);
                        pop_addr_in = tail_base + 1'b1;
                     end
                  end
               end
               default: begin
                  s1_in.event_res = EV_NONE;
               end
            endcase
         end
      end
      s1_in.queued    = QUEUED_W'(fill_in);
      s1_in.ready_res = (fill_in != '0);
   end

   // output payload: status from s1, byte from the memory read
   always_comb begin
      rsp_in           = s1_ff;
      rsp_in.data_byte = s1_byte_ff ? rd_data_ff : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         prev_ff      <= '0;
         last_ff      <= '0;
         cnt_ff       <= '0;
         exp_len_ff   <= '0;
         sum_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         pop_busy_ff  <= 1'b0;
         pop_len_ff   <= '0;
         pop_cnt_ff   <= '0;
         pop_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         prev_ff      <= prev_in;
         last_ff      <= last_in;
         cnt_ff       <= cnt_in;
         exp_len_ff   <= exp_len_in;
         sum_ff       <= sum_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         pop_busy_ff  <= pop_busy_in;
         pop_len_ff   <= pop_len_in;
         pop_cnt_ff   <= pop_cnt_in;
         pop_addr_ff  <= pop_addr_in;
         if (adv) begin
            s1_valid_ff  <= s1_valid_in;
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff      <= s1_in;
         s1_byte_ff <= s1_byte_in;
         rsp_ff     <= rsp_in;
      end
   end

   // packet memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pkt_mem_ff[mem_wa] <= cmd.data;
      end
      if (adv) begin
         rd_data_ff <= pkt_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_len_ff[head_ff] <= exp_len_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- rtl/checksummed_packet_deframer_queue_unit.sv -----
// top level of the checksummed packet deframer with receive queue
// depends on cpdq_pkg, cpdq_front, cpdq_back

//  channel  | ports                              | moves
//  ---------+------------------------------------+-----------------------------------
//  request  | req_valid, req_stall, req_payload  | rx byte, timeout or pop request
//  result   | rsp_valid, rsp_stall, rsp_payload  | status or popped byte with last
//  csr      | csr_wr_en, csr_index, csr_wr_data  | header byte writes, no read-back
//
// an rx, timeout or empty pop request yields one back end result; a pop of a packet of
// length l streams l results, one per cycle while not stalled, paced by the single read
// port of the packet memory. results pass s1 and the output register once the back end
// takes a request. reset is synchronous and active high; it clears control state only,
// packet memory and slot lengths are left as they are. a stalled result holds the output
// register and the back end; requests keep filling a four-deep command queue until full

module checksummed_packet_deframer_queue_unit #(
   parameter int QUEUE_SLOTS      = cpdq_pkg::QUEUE_SLOTS_DEF,
   parameter int MAX_PACKET_BYTES = cpdq_pkg::MAX_PACKET_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  cpdq_pkg::req_type                  req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output cpdq_pkg::rsp_type                  rsp_payload,
   input  logic                               csr_wr_en,
   input  logic [cpdq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cpdq_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import cpdq_pkg::*;

   // header match registers
   logic [7:0] header_first_ff;
   logic [7:0] header_second_ff;

   // front to back command handoff
   logic       cmd_valid;
   logic       cmd_take;
   cmd_type    cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_first_ff  <= HEADER_FIRST_RST;
         header_second_ff <= HEADER_SECOND_RST;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_HEADER_FIRST) begin
            header_first_ff <= csr_wr_data;
         end
         if (csr_index == CSR_HEADER_SECOND) begin
            header_second_ff <= csr_wr_data;
         end
      end
   end

   // accept and classify requests
   cpdq_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cmd_valid   (cmd_valid),
      .cmd_take    (cmd_take),
      .cmd         (cmd)
   );

   // framer, packet ring and pop streaming
   cpdq_back #(
      .QUEUE_SLOTS      (QUEUE_SLOTS),
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .header_first  (header_first_ff),
      .header_second (header_second_ff),
      .cmd_valid     (cmd_valid),
      .cmd_take      (cmd_take),
      .cmd           (cmd),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload)
   );

`ifndef SYNTH
   // anything but a popped byte closes its request
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.event_res != EV_BYTE |-> rsp_payload.last)
      else $error("status result without last");

   // an empty pop reports an empty queue
   a_empty_queue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.event_res == EV_EMPTY |->
         rsp_payload.queued == '0 && !rsp_payload.ready_res)
      else $error("empty result with packets queued");

   // a packet streams without gaps once its first byte is taken
   a_pop_stream: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_payload.event_res == EV_BYTE && !rsp_payload.last
         |=> rsp_valid && rsp_payload.event_res == EV_BYTE)
      else $error("gap inside popped packet");
`endif

endmodule
